// File: rtl/ptb_pkg.sv
// Shared types and constants of the palindromic tree builder.
// Holds port widths, mode and status codes, and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package ptb_pkg;

  localparam int MAX_LEN_DEF     = 1024;
  localparam int SYMBOL_BITS_DEF = 4;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 80;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 2;

  localparam int SYM_FIELD_W   = 4;
  localparam int INDEX_FIELD_W = 11;
  localparam int ID_FIELD_W    = 11;
  localparam int LEN_FIELD_W   = 11;
  localparam int LINK_FIELD_W  = 12;
  localparam int START_FIELD_W = 10;
  localparam int OCC_W         = 20;
  localparam int COUNT_FIELD_W = 11;

  localparam logic [OCC_W-1:0] COUNT_MAX = 20'hFFFFF;

  localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_AGG  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FROZEN = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd3;

  localparam logic [1:0] EM_CUR   = 2'd0;
  localparam logic [1:0] EM_EMPTY = 2'd1;
  localparam logic [1:0] EM_IDX   = 2'd2;
  localparam logic [1:0] EM_CHILD = 2'd3;

  localparam logic [1:0] NSEL_WALK = 2'd0;
  localparam logic [1:0] NSEL_AGG  = 2'd1;
  localparam logic [1:0] NSEL_EMIT = 2'd2;

  localparam logic [1:0] OSEL_AGG  = 2'd0;
  localparam logic [1:0] OSEL_LINK = 2'd1;
  localparam logic [1:0] OSEL_EMIT = 2'd2;

  localparam logic [1:0] WALK_HOLD  = 2'd0;
  localparam logic [1:0] WALK_CUR   = 2'd1;
  localparam logic [1:0] WALK_LINK  = 2'd2;
  localparam logic [1:0] WALK_BLINK = 2'd3;

  typedef struct packed {
    logic                clr_step;
    logic                in_load;
    logic                em_set;
    logic [1:0]          em_sel;
    logic [STATUS_W-1:0] em_status;
    logic                em_bump;
    logic                node_rd;
    logic [1:0]          node_sel;
    logic                occ_rd;
    logic [1:0]          occ_sel;
    logic [1:0]          walk_op;
    logic                tx_rd;
    logic                base_set;
    logic                child_rd;
    logic                hit_commit;
    logic                lk_set;
    logic                lk_one;
    logic                agg_start;
    logic                agg_hold;
    logic                agg_wr;
    logic                set_frozen;
    logic                out_form;
    logic                out_new;
    logic                out_bad;
  } ptb_cmd_t;

  typedef struct packed {
    logic              clr_done;
    logic [MODE_W-1:0] mode;
    logic              frozen;
    logic              full;
    logic              idx_ok;
    logic              seed;
    logic              too_long;
    logic              tx_match;
    logic              child_hit;
    logic              base_seed;
    logic              agg_last;
    logic              out_free;
  } ptb_sts_t;

endpackage

`default_nettype wire

// File: rtl/palindromic_tree_builder.sv
// Top level of the palindromic tree builder (eertree) over a symbol stream.
// The input channel takes one request per transfer: in_tuser holds the mode (push,
// aggregate, read) and in_tdata the symbol and the node index. Every request gives
// exactly one result transfer: out_tdata holds the node data, out_tuser the status.
// Requests are handled one at a time, and the next one can be accepted in the cycle after
// the result is formed. A request with a bad index or mode goes from dispatch straight
// to its result; a read, a rejected push or a repeated aggregate first reads the node
// and count memories. A push walks the suffix links from the current node until a node
// fits, with a node memory read and, where needed, a text memory read per step; a new
// node whose link has to be searched walks the suffix links a second time in the same
// way. An aggregate does a read, a read and a write of the count memory for each node,
// then reads out its result.
// After reset the child table is swept to empty, one entry per cycle, over
// (MAX_LEN + 2) * 2**SYMBOL_BITS entries (16416 by default); no request is accepted
// until that pass is over. The result waits in an output register while the receiver
// stalls; the next request is accepted meanwhile and its result is held back until
// the register is free.
// Depends on ptb_pkg, ptb_ctrl and ptb_dpath.
`default_nettype none

module palindromic_tree_builder
  import ptb_pkg::*;
#(
  parameter int MAX_LEN     = MAX_LEN_DEF,
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // symbol[3:0], node_index[14:4], zero
  input  wire logic [MODE_W-1:0]     in_tuser,   // mode[1:0]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // node_id, pal_length, link_id, is_new,
                                                 // start_pos, occurrences, node_count, zero
  output logic [STATUS_W-1:0]        out_tuser   // status[1:0]
);

  ptb_cmd_t cmd;
  ptb_sts_t sts;

  ptb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ptb_dpath #(
    .MAX_LEN     (MAX_LEN),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

`default_nettype wire

// File: rtl/ptb_ctrl.sv
// Controller state machine of the palindromic tree builder.
// Sequences clearing, suffix-link walks, node creation, aggregation and reads; uses ptb_pkg.
`default_nettype none

module ptb_ctrl
  import ptb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire ptb_sts_t sts,
  output ptb_cmd_t      cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_BAD   = 4'd3;
  localparam logic [3:0] S_E_RD  = 4'd4;
  localparam logic [3:0] S_E_FM  = 4'd5;
  localparam logic [3:0] S_W_RD  = 4'd6;
  localparam logic [3:0] S_W_LEN = 4'd7;
  localparam logic [3:0] S_W_TX  = 4'd8;
  localparam logic [3:0] S_C_CHK = 4'd9;
  localparam logic [3:0] S_L_CHK = 4'd10;
  localparam logic [3:0] S_NEW   = 4'd11;
  localparam logic [3:0] S_A_RD  = 4'd12;
  localparam logic [3:0] S_A_T   = 4'd13;
  localparam logic [3:0] S_A_W   = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic       pass_r, pass_nxt;
  logic       found;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    pass_nxt  = pass_r;
    found     = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.in_load = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_BAD;
        if (sts.mode == MODE_PUSH) begin
          if (sts.frozen || sts.full) begin
            cmd.em_set    = 1'b1;
            cmd.em_sel    = EM_CUR;
            cmd.em_status = sts.frozen ? ST_FROZEN : ST_FULL;
            state_nxt     = S_E_RD;
          end else begin
            cmd.walk_op = WALK_CUR;
            pass_nxt    = 1'b0;
            state_nxt   = S_W_RD;
          end
        end else if (sts.mode == MODE_AGG) begin
          if (sts.frozen) begin
            cmd.em_set    = 1'b1;
            cmd.em_sel    = EM_EMPTY;
            cmd.em_status = ST_FROZEN;
            state_nxt     = S_E_RD;
          end else begin
            cmd.agg_start = 1'b1;
            state_nxt     = S_A_RD;
          end
        end else if (sts.mode == MODE_READ && sts.idx_ok) begin
          cmd.em_set    = 1'b1;
          cmd.em_sel    = EM_IDX;
          cmd.em_status = ST_OK;
          state_nxt     = S_E_RD;
        end
      end
      S_BAD: begin
        if (sts.out_free) begin
          cmd.out_bad = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_E_RD: begin
        cmd.node_rd  = 1'b1;
        cmd.node_sel = NSEL_EMIT;
        cmd.occ_rd   = 1'b1;
        cmd.occ_sel  = OSEL_EMIT;
        state_nxt    = S_E_FM;
      end
      S_E_FM: begin
        if (sts.out_free) begin
          cmd.out_form = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_W_RD: begin
        cmd.node_rd  = 1'b1;
        cmd.node_sel = NSEL_WALK;
        state_nxt    = S_W_LEN;
      end
      S_W_LEN: begin
        if (sts.seed) begin
          found = 1'b1;
        end else if (sts.too_long) begin
          cmd.walk_op = WALK_LINK;
          state_nxt   = S_W_RD;
        end else begin
          cmd.tx_rd = 1'b1;
          state_nxt = S_W_TX;
        end
      end
      S_W_TX: begin
        if (sts.tx_match) begin
          found = 1'b1;
        end else begin
          cmd.walk_op = WALK_LINK;
          state_nxt   = S_W_RD;
        end
      end
      S_C_CHK: begin
        if (sts.child_hit) begin
          cmd.em_set     = 1'b1;
          cmd.em_sel     = EM_CHILD;
          cmd.em_status  = ST_OK;
          cmd.em_bump    = 1'b1;
          cmd.hit_commit = 1'b1;
          state_nxt      = S_E_RD;
        end else if (sts.base_seed) begin
          cmd.lk_set = 1'b1;
          cmd.lk_one = 1'b1;
          state_nxt  = S_NEW;
        end else begin
          cmd.walk_op = WALK_BLINK;
          pass_nxt    = 1'b1;
          state_nxt   = S_W_RD;
        end
      end
      S_L_CHK: begin
        cmd.lk_set = 1'b1;
        state_nxt  = S_NEW;
      end
      S_NEW: begin
        if (sts.out_free) begin
          cmd.out_new = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_A_RD: begin
        cmd.node_rd  = 1'b1;
        cmd.node_sel = NSEL_AGG;
        cmd.occ_rd   = 1'b1;
        cmd.occ_sel  = OSEL_AGG;
        state_nxt    = S_A_T;
      end
      S_A_T: begin
        cmd.agg_hold = 1'b1;
        cmd.occ_rd   = 1'b1;
        cmd.occ_sel  = OSEL_LINK;
        state_nxt    = S_A_W;
      end
      S_A_W: begin
        cmd.agg_wr = 1'b1;
        if (sts.agg_last) begin
          cmd.set_frozen = 1'b1;
          cmd.em_set     = 1'b1;
          cmd.em_sel     = EM_EMPTY;
          cmd.em_status  = ST_OK;
          state_nxt      = S_E_RD;
        end else begin
          state_nxt = S_A_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (found) begin
      cmd.child_rd = 1'b1;
      if (!pass_r) begin
        cmd.base_set = 1'b1;
        state_nxt    = S_C_CHK;
      end else begin
        state_nxt = S_L_CHK;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/ptb_dpath.sv
// Datapath of the palindromic tree builder: text, node, count and child memories,
// walk registers and the output register. Driven by ptb_ctrl; uses ptb_pkg.
`default_nettype none

module ptb_dpath
  import ptb_pkg::*;
#(
  parameter int MAX_LEN     = MAX_LEN_DEF,
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [MODE_W-1:0]     in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [STATUS_W-1:0]        out_tuser,
  input  wire ptb_cmd_t              cmd,
  output ptb_sts_t                   sts
);

  localparam int NB     = $clog2(MAX_LEN + 1);
  localparam int TA     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int SLOTS  = MAX_LEN + 2;
  localparam int SW     = $clog2(SLOTS);
  localparam int LW     = NB + 1;
  localparam int CDEPTH = SLOTS * (2 ** SYMBOL_BITS);
  localparam int CW     = SW + SYMBOL_BITS;
  localparam int NW     = LW + TA + SW;

  function automatic logic [OCC_W-1:0] sat_add(input logic [OCC_W-1:0] a,
                                               input logic [OCC_W-1:0] b);
    logic [OCC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, COUNT_MAX}) ? COUNT_MAX : s[OCC_W-1:0];
  endfunction

  logic [SYMBOL_BITS-1:0] text_mem  [MAX_LEN];
  logic [NW-1:0]          node_mem  [SLOTS];
  logic [OCC_W-1:0]       occ_mem   [SLOTS];
  logic [SW-1:0]          child_mem [CDEPTH];

  logic [CW-1:0]            clr_r;
  logic [NB-1:0]            n_r;
  logic [SW-1:0]            total_r;
  logic [SW-1:0]            cur_r;
  logic                     frozen_r;
  logic                     out_valid_r;
  logic [MODE_W-1:0]        mode_r;
  logic [SYMBOL_BITS-1:0]   sym_r;
  logic [INDEX_FIELD_W-1:0] idx_r;
  logic [SW-1:0]            walk_r;
  logic [SW-1:0]            base_r;
  logic signed [LW-1:0]     blen_r;
  logic [SW-1:0]            blink_r;
  logic [SW-1:0]            lk_r;
  logic [SW-1:0]            em_slot_r;
  logic [STATUS_W-1:0]      em_status_r;
  logic                     em_bump_r;
  logic [SW-1:0]            agg_s_r;
  logic [SW-1:0]            agg_t_r;
  logic [OCC_W-1:0]         acc_r;
  logic [OUT_DATA_W-1:0]    out_data_r;
  logic [STATUS_W-1:0]      out_user_r;

  logic [NW-1:0]          nd_q;
  logic [OCC_W-1:0]       oc_q;
  logic [SYMBOL_BITS-1:0] tx_q;
  logic [SW-1:0]          cd_q;

  logic signed [LW-1:0] nd_len;
  logic [TA-1:0]        nd_start;
  logic [SW-1:0]        nd_link;
  logic                 out_free;
  logic                 clr_init;
  logic [SW-1:0]        new_slot;
  logic signed [LW-1:0] new_len;
  logic [TA-1:0]        new_start;
  logic [OCC_W-1:0]     bumped;

  assign nd_len   = nd_q[NW-1 -: LW];
  assign nd_start = nd_q[SW +: TA];
  assign nd_link  = nd_q[SW-1:0];
  assign out_free = !out_valid_r || out_tready;
  assign clr_init = (clr_r == CW'(0)) || (clr_r == CW'(1));
  assign new_slot = total_r + SW'(1);
  assign new_len  = blen_r + LW'(2);
  assign new_start = TA'(LW'(n_r) - blen_r - LW'(1));
  assign bumped   = sat_add(oc_q, OCC_W'(1));

  // Memory port address and write selection.
  logic [SW-1:0]          node_ra;
  logic                   node_we;
  logic [SW-1:0]          node_wa;
  logic [NW-1:0]          node_wd;
  logic [SW-1:0]          occ_ra;
  logic                   occ_we;
  logic [SW-1:0]          occ_wa;
  logic [OCC_W-1:0]       occ_wd;
  logic                   child_we;
  logic [CW-1:0]          child_wa;
  logic [SW-1:0]          child_wd;
  logic [TA-1:0]          text_ra;

  always_comb begin
    unique case (cmd.node_sel)
      NSEL_AGG:  node_ra = agg_s_r;
      NSEL_EMIT: node_ra = em_slot_r;
      default:   node_ra = walk_r;
    endcase
    unique case (cmd.occ_sel)
      OSEL_LINK: occ_ra = nd_link;
      OSEL_EMIT: occ_ra = em_slot_r;
      default:   occ_ra = agg_s_r;
    endcase
    text_ra = TA'(LW'(n_r) - nd_len - LW'(1));

    node_we = 1'b0;
    node_wa = new_slot;
    node_wd = {new_len, new_start, lk_r};
    if (cmd.clr_step && clr_init) begin
      node_we = 1'b1;
      node_wa = SW'(clr_r);
      node_wd = (clr_r == CW'(0)) ? {{LW{1'b1}}, {TA{1'b0}}, {SW{1'b0}}} : '0;
    end else if (cmd.out_new) begin
      node_we = 1'b1;
    end

    occ_we = 1'b0;
    occ_wa = em_slot_r;
    occ_wd = bumped;
    if (cmd.clr_step && clr_init) begin
      occ_we = 1'b1;
      occ_wa = SW'(clr_r);
      occ_wd = '0;
    end else if (cmd.out_new) begin
      occ_we = 1'b1;
      occ_wa = new_slot;
      occ_wd = OCC_W'(1);
    end else if (cmd.agg_wr) begin
      occ_we = 1'b1;
      occ_wa = agg_t_r;
      occ_wd = sat_add(oc_q, acc_r);
    end else if (cmd.out_form && em_bump_r) begin
      occ_we = 1'b1;
    end

    child_we = cmd.clr_step || cmd.out_new;
    child_wa = cmd.clr_step ? clr_r : {base_r, sym_r};
    child_wd = cmd.clr_step ? '0 : new_slot;
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    if (cmd.node_rd) begin
      nd_q <= node_mem[node_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (occ_we) begin
      occ_mem[occ_wa] <= occ_wd;
    end
    if (cmd.occ_rd) begin
      oc_q <= occ_mem[occ_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (child_we) begin
      child_mem[child_wa] <= child_wd;
    end
    if (cmd.child_rd) begin
      cd_q <= child_mem[{walk_r, sym_r}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.base_set) begin
      text_mem[TA'(n_r)] <= sym_r;
    end
    if (cmd.tx_rd) begin
      tx_q <= text_mem[text_ra];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      n_r         <= '0;
      total_r     <= SW'(1);
      cur_r       <= SW'(1);
      frozen_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_r <= clr_r + CW'(1);
      end
      if (cmd.hit_commit) begin
        cur_r <= cd_q;
        n_r   <= n_r + NB'(1);
      end else if (cmd.out_new) begin
        cur_r   <= new_slot;
        n_r     <= n_r + NB'(1);
        total_r <= new_slot;
      end
      if (cmd.set_frozen) begin
        frozen_r <= 1'b1;
      end
      if (cmd.out_form || cmd.out_new || cmd.out_bad) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      mode_r <= in_tuser;
      sym_r  <= SYMBOL_BITS'(in_tdata[SYM_FIELD_W-1:0]);
      idx_r  <= in_tdata[SYM_FIELD_W +: INDEX_FIELD_W];
    end
    unique case (cmd.walk_op)
      WALK_CUR:   walk_r <= cur_r;
      WALK_LINK:  walk_r <= nd_link;
      WALK_BLINK: walk_r <= blink_r;
      default:    walk_r <= walk_r;
    endcase
    if (cmd.base_set) begin
      base_r  <= walk_r;
      blen_r  <= nd_len;
      blink_r <= nd_link;
    end
    if (cmd.lk_set) begin
      lk_r <= (cmd.lk_one || cd_q == '0) ? SW'(1) : cd_q;
    end
    if (cmd.em_set) begin
      em_status_r <= cmd.em_status;
      em_bump_r   <= cmd.em_bump;
      unique case (cmd.em_sel)
        EM_EMPTY: em_slot_r <= SW'(1);
        EM_IDX:   em_slot_r <= SW'(idx_r) + SW'(1);
        EM_CHILD: em_slot_r <= cd_q;
        default:  em_slot_r <= cur_r;
      endcase
    end
    if (cmd.agg_start) begin
      agg_s_r <= total_r;
    end else if (cmd.agg_wr) begin
      agg_s_r <= agg_s_r - SW'(1);
    end
    if (cmd.agg_hold) begin
      acc_r   <= oc_q;
      agg_t_r <= nd_link;
    end
  end

  // Result fields.
  logic [ID_FIELD_W-1:0]    f_id;
  logic [LEN_FIELD_W-1:0]   f_len;
  logic [LINK_FIELD_W-1:0]  f_link;
  logic                     f_new;
  logic [START_FIELD_W-1:0] f_start;
  logic [OCC_W-1:0]         f_occ;
  logic [STATUS_W-1:0]      f_status;

  always_comb begin
    f_id     = ID_FIELD_W'(em_slot_r - SW'(1));
    f_len    = LEN_FIELD_W'(nd_len);
    f_link   = LINK_FIELD_W'(nd_link) - LINK_FIELD_W'(1);
    f_new    = 1'b0;
    f_start  = START_FIELD_W'(nd_start);
    f_occ    = em_bump_r ? bumped : oc_q;
    f_status = em_status_r;
    if (cmd.out_new) begin
      f_id     = ID_FIELD_W'(total_r);
      f_len    = LEN_FIELD_W'(new_len);
      f_link   = LINK_FIELD_W'(lk_r) - LINK_FIELD_W'(1);
      f_new    = 1'b1;
      f_start  = START_FIELD_W'(new_start);
      f_occ    = OCC_W'(1);
      f_status = ST_OK;
    end else if (cmd.out_bad) begin
      f_id     = '0;
      f_len    = '0;
      f_link   = '0;
      f_start  = '0;
      f_occ    = '0;
      f_status = ST_BADIDX;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_form || cmd.out_new || cmd.out_bad) begin
      out_data_r <= {4'b0, COUNT_FIELD_W'(cmd.out_new ? new_slot : total_r), f_occ, f_start,
                     f_new, f_link, f_len, f_id};
      out_user_r <= f_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    sts           = '0;
    sts.clr_done  = (clr_r == CW'(CDEPTH - 1));
    sts.mode      = mode_r;
    sts.frozen    = frozen_r;
    sts.full      = (n_r == NB'(MAX_LEN));
    sts.idx_ok    = (32'(idx_r) < 32'(total_r));
    sts.seed      = nd_len[LW-1];
    sts.too_long  = (NB'(nd_len) >= n_r);
    sts.tx_match  = (tx_q == sym_r);
    sts.child_hit = (cd_q != '0);
    sts.base_seed = blen_r[LW-1];
    sts.agg_last  = (agg_s_r == SW'(1));
    sts.out_free  = out_free;
  end

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for palindromic_tree_builder: pushes, reads, aggregates and
// rejected requests are driven with random idling; a class predicts every reply.
// Depends on ptb_pkg and the palindromic_tree_builder RTL.
`timescale 1ns / 100ps

module tb;
  import ptb_pkg::*;

  localparam int SLOTS    = MAX_LEN_DEF + 2;
  localparam int SYMS     = 1 << SYMBOL_BITS_DEF;
  localparam int LIMIT    = 600000;
  localparam int HOLD_LEN = 400;

  typedef struct packed {
    logic [COUNT_FIELD_W-1:0] node_count;
    logic [OCC_W-1:0]         occurrences;
    logic [START_FIELD_W-1:0] start_pos;
    logic                     is_new;
    logic [LINK_FIELD_W-1:0]  link_id;
    logic [LEN_FIELD_W-1:0]   pal_length;
    logic [ID_FIELD_W-1:0]    node_id;
    logic [STATUS_W-1:0]      status;
  } node_reply_t;

  class eertree_model;
    int          pal_len[SLOTS];
    int          pal_start[SLOTS];
    int          suffix_link[SLOTS];
    int          occ[SLOTS];
    int          child[SLOTS*SYMS];
    int          text[MAX_LEN_DEF];
    int          text_len;
    int          total;
    int          longest;
    bit          frozen;
    int          errors;
    node_reply_t expected_nodes[$];

    function new();
      foreach (child[i]) child[i] = 0;
      foreach (occ[i]) occ[i] = 0;
      pal_len[0] = -1;
      pal_len[1] = 0;
      pal_start[1] = 0;
      suffix_link[0] = 0;
      suffix_link[1] = 0;
      text_len = 0;
      total = 1;
      longest = 1;
      frozen = 0;
      errors = 0;
    endfunction

    function bit fits(int s, int c, int n);
      if (pal_len[s] < 0) return 1;
      if (pal_len[s] + 1 > n) return 0;
      return text[n - pal_len[s] - 1] == c;
    endfunction

    function node_reply_t reply_of(int s, bit fresh, logic [STATUS_W-1:0] st);
      node_reply_t r;
      r.node_id     = ID_FIELD_W'(s - 1);
      r.pal_length  = LEN_FIELD_W'(pal_len[s]);
      r.link_id     = LINK_FIELD_W'(suffix_link[s] - 1);
      r.is_new      = fresh;
      r.start_pos   = START_FIELD_W'(pal_start[s]);
      r.occurrences = OCC_W'(occ[s]);
      r.node_count  = COUNT_FIELD_W'(total);
      r.status      = st;
      return r;
    endfunction

    function node_reply_t push(int c);
      int cur, ch, w, lk, n;
      bit fresh;
      n = text_len;
      cur = longest;
      fresh = 0;
      if (frozen) return reply_of(longest, 0, ST_FROZEN);
      if (n >= MAX_LEN_DEF) return reply_of(longest, 0, ST_FULL);
      while (!fits(cur, c, n)) cur = suffix_link[cur];
      text[n] = c;
      text_len = n + 1;
      ch = child[cur*SYMS + c];
      if (ch == 0) begin
        ch = total + 1;
        total++;
        pal_len[ch] = pal_len[cur] + 2;
        pal_start[ch] = n - pal_len[cur] - 1;
        if (pal_len[cur] < 0) begin
          lk = 1;
        end else begin
          w = suffix_link[cur];
          while (!fits(w, c, n)) w = suffix_link[w];
          lk = child[w*SYMS + c];
          if (lk == 0) lk = 1;
        end
        suffix_link[ch] = lk;
        occ[ch] = 0;
        child[cur*SYMS + c] = ch;
        fresh = 1;
      end
      if (occ[ch] < COUNT_MAX) occ[ch]++;
      longest = ch;
      return reply_of(ch, fresh, ST_OK);
    endfunction

    function node_reply_t aggregate();
      int sum;
      if (frozen) return reply_of(1, 0, ST_FROZEN);
      for (int s = total; s >= 1; s--) begin
        sum = occ[suffix_link[s]] + occ[s];
        occ[suffix_link[s]] = (sum > COUNT_MAX) ? COUNT_MAX : sum;
      end
      frozen = 1;
      return reply_of(1, 0, ST_OK);
    endfunction

    function void note_request(logic [MODE_W-1:0] mode, logic [3:0] sym, logic [10:0] idx);
      node_reply_t r;
      if (mode == MODE_PUSH) begin
        r = push(sym);
      end else if (mode == MODE_AGG) begin
        r = aggregate();
      end else if (mode == MODE_READ && idx < total) begin
        r = reply_of(idx + 1, 0, ST_OK);
      end else begin
        r = '0;
        r.node_count = COUNT_FIELD_W'(total);
        r.status = ST_BADIDX;
      end
      expected_nodes = {expected_nodes, r};
    endfunction

    function void check_reply(node_reply_t got);
      node_reply_t exp;
      if (expected_nodes.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = expected_nodes.pop_front();
      if (got.node_id != exp.node_id)
        $display("%0t: node_id exp %0d got %0d", $time, exp.node_id, got.node_id);
      if (got.pal_length != exp.pal_length)
        $display("%0t: pal_length exp %0d got %0d", $time, exp.pal_length, got.pal_length);
      if (got.link_id != exp.link_id)
        $display("%0t: link_id exp %h got %h", $time, exp.link_id, got.link_id);
      if (got.is_new != exp.is_new)
        $display("%0t: is_new exp %0d got %0d", $time, exp.is_new, got.is_new);
      if (got.start_pos != exp.start_pos)
        $display("%0t: start_pos exp %0d got %0d", $time, exp.start_pos, got.start_pos);
      if (got.occurrences != exp.occurrences)
        $display("%0t: occurrences exp %0d got %0d", $time, exp.occurrences,
                 got.occurrences);
      if (got.node_count != exp.node_count)
        $display("%0t: node_count exp %0d got %0d", $time, exp.node_count, got.node_count);
      if (got.status != exp.status)
        $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
      if (got != exp) errors++;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [MODE_W-1:0]     in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;

  eertree_model model = new();
  int  cycles = 0;
  int  hold_left = 0;
  bit  hold_go = 0;
  bit  hold_done = 0;
  bit  no_idle = 0;
  int  pushes_sent = 0;
  int  sent = 0;

  palindromic_tree_builder u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      model.note_request(in_tuser, in_tdata[3:0], in_tdata[14:4]);
    if (rst_n && out_tvalid && out_tready)
      model.check_reply({out_tdata[75:0], out_tuser});
  end

  // The receiver stalls once for a long stretch, is always ready while no_idle is set, and otherwise idles at random.
  always @(posedge clk) begin
    if (hold_go && !hold_done && hold_left == 0) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(99) >= 38);
    end
  end

  task automatic send(logic [MODE_W-1:0] mode, logic [3:0] sym, logic [10:0] idx);
    while (!no_idle && $urandom_range(99) < 38) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {1'b0, idx, sym};
    do @(posedge clk); while (!in_tready);
    if (mode == MODE_PUSH) pushes_sent++;
    sent++;
    no_idle = (sent >= 150 && sent < 260);
    if (sent == 300) hold_go = 1;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (model.expected_nodes.size() != 0) @(posedge clk);
  endtask

  task automatic random_traffic();
    int base, span, r;
    base = 0;
    span = 2;
    while (sent < 350) begin
      if ($urandom_range(31) == 0) begin
        span = $urandom_range(8) == 0 ? SYMS : $urandom_range(1, 3);
        base = $urandom_range(SYMS - span);
      end
      r = $urandom_range(99);
      if (sent == 280) drain();
      if (r < 86) begin
        send(MODE_PUSH, 4'(base + $urandom_range(span - 1)), 11'($urandom));
      end else if (r < 96) begin
        send(MODE_READ, 4'($urandom), 11'($urandom_range(model.total + 1)));
      end else if (r < 98) begin
        send(MODE_READ, 4'($urandom), 11'($urandom));
      end else begin
        send(2'd3, 4'($urandom), 11'($urandom));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    send(MODE_READ, 4'd0, 11'd0);
    send(MODE_READ, 4'd0, 11'd2047);
    send(MODE_READ, 4'd15, 11'd1024);
    send(2'd3, 4'd15, 11'd0);
    send(MODE_PUSH, 4'd0, 11'd0);
    send(MODE_PUSH, 4'd15, 11'd2047);
    send(MODE_PUSH, 4'd0, 11'd0);
    send(MODE_PUSH, 4'd0, 11'd0);
    send(MODE_PUSH, 4'd15, 11'd0);
    send(MODE_PUSH, 4'd0, 11'd0);
    send(MODE_PUSH, 4'd0, 11'd0);
    send(MODE_READ, 4'd0, 11'd3);
    send(MODE_READ, 4'd0, 11'd1);
    random_traffic();
    send(MODE_READ, 4'd0, 11'd1024);
    send(MODE_AGG, 4'd0, 11'd0);
    send(MODE_READ, 4'd0, 11'd0);
    for (int i = 0; i < 40; i++) send(MODE_READ, 4'd0, 11'($urandom_range(model.total)));
    send(MODE_READ, 4'd0, 11'd1024);
    send(MODE_AGG, 4'd0, 11'd0);
    send(MODE_PUSH, 4'd5, 11'd0);
    send(2'd3, 4'd0, 11'd0);
    drain();
    repeat (20) @(posedge clk);
    if (model.errors == 0 && model.expected_nodes.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
